### sv/rmth_pkg.sv
package rmth_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 18;
    localparam int COUNT_WIDTH    = 11;

endpackage

### sv/rmth_heap.sv
module rmth_heap #(
    parameter int DEPTH      = 512,
    parameter int DATA_WIDTH = 18,
    parameter int AW         = 9,
    parameter int SW         = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         is_max,
    input  logic                         push_start,
    input  logic                         pop_start,
    input  logic signed [DATA_WIDTH-1:0] push_value,
    output logic                         busy,
    output logic [SW-1:0]                size,
    output logic signed [DATA_WIDTH-1:0] top
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RDA,
        S_DN_RDB,
        S_DN_CMP
    } state_t;

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    state_t                       state_reg, state_next;
    logic [SW-1:0]                size_reg, size_next;
    logic [SW-1:0]                idx_reg, idx_next;
    logic [SW-1:0]                n_reg, n_next;
    logic signed [DATA_WIDTH-1:0] val_reg, val_next;
    logic signed [DATA_WIDTH-1:0] ca_reg, ca_next;
    logic signed [DATA_WIDTH-1:0] top_reg, top_next;
    logic [AW-1:0]                rd_addr;
    logic signed [DATA_WIDTH-1:0] rd_data;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;
    logic [SW-1:0]                parent;
    logic [SW:0]                  child;
    logic                         above_up;
    logic                         b_wins;
    logic                         c_above;
    logic signed [DATA_WIDTH-1:0] cbest;
    logic [SW:0]                  cidx;

    assign busy = (state_reg != S_IDLE);
    assign size = size_reg;
    assign top  = top_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign parent   = (idx_reg - SW'(1)) >> 1;
    assign child    = {idx_reg, 1'b1};
    assign above_up = is_max ? (val_reg > rd_data) : (val_reg < rd_data);
    assign b_wins   = ((child + (SW+1)'(1)) < {1'b0, n_reg})
                      && (is_max ? (rd_data > ca_reg) : (rd_data < ca_reg));
    assign cbest    = b_wins ? rd_data : ca_reg;
    assign cidx     = b_wins ? child + (SW+1)'(1) : child;
    assign c_above  = is_max ? (cbest > val_reg) : (cbest < val_reg);

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        val_next   = val_reg;
        ca_next    = ca_reg;
        top_next   = top_reg;
        rd_addr    = AW'(idx_reg);
        wr_en      = 1'b0;
        wr_addr    = AW'(idx_reg);
        wr_data    = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push_start)
                begin
                    val_next  = push_value;
                    idx_next  = size_reg;
                    size_next = size_reg + SW'(1);
                    state_next = S_UP_RD;
                end
                else if (pop_start)
                begin
                    n_next    = size_reg - SW'(1);
                    size_next = size_reg - SW'(1);
                    idx_next  = '0;
                    rd_addr   = AW'(size_reg - SW'(1));
                    state_next = (size_reg == SW'(1)) ? S_IDLE : S_DN_LAST;
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en    = 1'b1;
                    top_next = val_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr = AW'(parent);
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (above_up)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    wr_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_LAST:
            begin
                val_next = rd_data;
                state_next = S_DN_RDA;
            end
            S_DN_RDA:
            begin
                if (child >= {1'b0, n_reg})
                begin
                    wr_en = 1'b1;
                    if (idx_reg == '0)
                    begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr = AW'(child);
                    state_next = S_DN_RDB;
                end
            end
            S_DN_RDB:
            begin
                ca_next = rd_data;
                rd_addr = AW'(child + (SW+1)'(1));
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (c_above)
                begin
                    wr_en   = 1'b1;
                    wr_data = cbest;
                    if (idx_reg == '0)
                    begin
                        top_next = cbest;
                    end
                    idx_next = SW'(cidx);
                    state_next = S_DN_RDA;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (idx_reg == '0)
                    begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        val_reg <= val_next;
        ca_reg  <= ca_next;
        top_reg <= top_next;
    end

endmodule

### sv/running_median_two_heaps_unit.sv
// Running median of a signed sample stream, kept in a lower max-heap and an
// upper min-heap held in two single-port memories.
// Input channel: value with valid/ready; one beat per sample.
// Output channel: median_x2 (twice the median), element_count and dropped,
// with valid/ready; exactly one beat per input beat.
// Sequence: an insert runs one push, or a push, a pop and a second push; a
// push climbs the heap a level at a time and a pop sinks a level at a time.
// A dropped sample skips both heaps and goes straight to its result beat.
// The sequencer takes one sample at a time: in_ready is low from acceptance
// until the result beat has been taken.
// Reset clears both heap sizes; heap memory is not cleared and needs no pass.
// While the receiver stalls, the result holds in its output register and no
// new sample is taken.
module running_median_two_heaps_unit #(
    parameter int CAPACITY   = rmth_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rmth_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH:0]   median_x2,
    output logic [rmth_pkg::COUNT_WIDTH-1:0] element_count,
    output logic                         dropped
);

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int TW    = $clog2(CAPACITY + 1);
    localparam int CW    = rmth_pkg::COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WAIT1,
        S_WAIT2,
        S_WAIT3,
        S_RESULT,
        S_OUT
    } state_t;

    state_t                       state_reg;
    logic signed [DATA_WIDTH-1:0] v_reg;
    logic                         to_lower_reg;
    logic                         move_reg;
    logic                         drop_reg;
    logic signed [DATA_WIDTH:0]   med_reg;
    logic [CW-1:0]                cnt_reg;

    logic                         lo_push, lo_pop, up_push, up_pop;
    logic signed [DATA_WIDTH-1:0] lo_pv, up_pv, lo_top, up_top;
    logic                         lo_busy, up_busy;
    logic [SW-1:0]                lo_size, up_size;
    logic [TW-1:0]                total;
    logic signed [DATA_WIDTH:0]   sum_tops, v2, lo2, up2;

    rmth_heap #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .AW(AW), .SW(SW)) u_lower (
        .clk(clk), .rst_n(rst_n), .is_max(1'b1),
        .push_start(lo_push), .pop_start(lo_pop), .push_value(lo_pv),
        .busy(lo_busy), .size(lo_size), .top(lo_top)
    );

    rmth_heap #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .AW(AW), .SW(SW)) u_upper (
        .clk(clk), .rst_n(rst_n), .is_max(1'b0),
        .push_start(up_push), .pop_start(up_pop), .push_value(up_pv),
        .busy(up_busy), .size(up_size), .top(up_top)
    );

    assign total    = TW'(lo_size) + TW'(up_size);
    assign sum_tops = (DATA_WIDTH+1)'(lo_top) + (DATA_WIDTH+1)'(up_top);
    assign v2       = {v_reg, 1'b0};
    assign lo2      = {lo_top, 1'b0};
    assign up2      = {up_top, 1'b0};

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign median_x2     = med_reg;
    assign element_count = cnt_reg;
    assign dropped       = drop_reg;

    // move the larger heap's top across, pop it, push the sample; or just push
    always_comb
    begin
        lo_push = 1'b0;
        lo_pop  = 1'b0;
        up_push = 1'b0;
        up_pop  = 1'b0;
        lo_pv   = v_reg;
        up_pv   = v_reg;
        if (state_reg == S_WAIT1 && !lo_busy && !up_busy)
        begin
            if (move_reg)
            begin
                if (to_lower_reg)
                begin
                    up_push = 1'b1;
                    up_pv   = lo_top;
                end
                else
                begin
                    lo_push = 1'b1;
                    lo_pv   = up_top;
                end
            end
            else
            begin
                lo_push = to_lower_reg;
                up_push = !to_lower_reg;
            end
        end
        else if (state_reg == S_WAIT2 && !lo_busy && !up_busy)
        begin
            lo_pop = to_lower_reg;
            up_pop = !to_lower_reg;
        end
        else if (state_reg == S_WAIT3 && !lo_busy && !up_busy)
        begin
            lo_push = to_lower_reg;
            up_push = !to_lower_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        v_reg     <= value;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    drop_reg <= 1'b0;
                    move_reg <= 1'b0;
                    if (total >= TW'(CAPACITY))
                    begin
                        drop_reg  <= 1'b1;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_WAIT1;
                        if (lo_size == up_size)
                        begin
                            to_lower_reg <= (lo_size == '0) || !(v2 > sum_tops);
                        end
                        else if (up_size > lo_size)
                        begin
                            to_lower_reg <= !(v_reg > up_top);
                            move_reg     <= (v_reg > up_top);
                        end
                        else
                        begin
                            to_lower_reg <= !(v_reg > lo_top);
                            move_reg     <= !(v_reg > lo_top);
                        end
                    end
                end
                S_WAIT1:
                begin
                    if (!lo_busy && !up_busy)
                    begin
                        state_reg <= move_reg ? S_WAIT2 : S_RESULT;
                    end
                end
                S_WAIT2:
                begin
                    if (!lo_busy && !up_busy)
                    begin
                        state_reg <= S_WAIT3;
                    end
                end
                S_WAIT3:
                begin
                    if (!lo_busy && !up_busy)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (!lo_busy && !up_busy)
                    begin
                        cnt_reg <= CW'(total);
                        if (lo_size == up_size)
                        begin
                            med_reg <= (lo_size == '0) ? '0 : sum_tops;
                        end
                        else if (up_size > lo_size)
                        begin
                            med_reg <= up2;
                        end
                        else
                        begin
                            med_reg <= lo2;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

class median_scoreboard;
    localparam int DEPTH = 512;
    localparam int CAP   = 1024;
    localparam int LO    = 0;
    localparam int HI    = 1;

    longint heap [2][DEPTH];
    int     fill [2];
    logic signed [18:0] exp_median [$];
    logic [10:0]        exp_count  [$];
    logic               exp_drop   [$];
    int mismatches;
    int beats;
    int drops;
    int orphans;

    function new();
        fill[LO] = 0;
        fill[HI] = 0;
        mismatches = 0;
        beats = 0;
        drops = 0;
        orphans = 0;
    endfunction

    function bit ranks(longint a, longint b, int side);
        return (side == LO) ? (a > b) : (a < b);
    endfunction

    function void push(int side, longint v);
        int i;
        int p;
        i = fill[side];
        fill[side]++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ranks(v, heap[side][p], side))
                break;
            heap[side][i] = heap[side][p];
            i = p;
        end
        heap[side][i] = v;
    endfunction

    function void pop(int side);
        int n;
        int i;
        int c;
        longint v;
        n = fill[side] - 1;
        fill[side] = n;
        i = 0;
        if (n == 0)
            return;
        v = heap[side][n];
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && ranks(heap[side][c + 1], heap[side][c], side))
                c = c + 1;
            if (!ranks(heap[side][c], v, side))
                break;
            heap[side][i] = heap[side][c];
            i = c;
        end
        heap[side][i] = v;
    endfunction

    function void note_sample(logic signed [17:0] sample);
        longint v;
        longint med;
        bit     full;
        v = longint'(sample);
        full = (fill[LO] + fill[HI] >= CAP);
        if (full)
            drops++;
        else if (fill[LO] == fill[HI])
        begin
            if (fill[LO] == 0 || !(2 * v > heap[LO][0] + heap[HI][0]))
                push(LO, v);
            else
                push(HI, v);
        end
        else if (fill[HI] > fill[LO])
        begin
            if (v > heap[HI][0])
            begin
                push(LO, heap[HI][0]);
                pop(HI);
                push(HI, v);
            end
            else
                push(LO, v);
        end
        else
        begin
            if (v > heap[LO][0])
                push(HI, v);
            else
            begin
                push(HI, heap[LO][0]);
                pop(LO);
                push(LO, v);
            end
        end
        if (fill[LO] == fill[HI])
            med = (fill[LO] == 0) ? 0 : heap[LO][0] + heap[HI][0];
        else if (fill[HI] > fill[LO])
            med = 2 * heap[HI][0];
        else
            med = 2 * heap[LO][0];
        exp_median.push_back(med[18:0]);
        exp_count.push_back(11'(fill[LO] + fill[HI]));
        exp_drop.push_back(full);
    endfunction

    function void check_beat(logic signed [18:0] med, logic [10:0] cnt, logic drp);
        logic signed [18:0] em;
        logic [10:0]        ec;
        logic               ed;
        beats++;
        if (exp_median.size() == 0)
        begin
            orphans++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: median_x2=%0d count=%0d dropped=%0b",
                         med, cnt, drp);
            return;
        end
        em = exp_median.pop_front();
        ec = exp_count.pop_front();
        ed = exp_drop.pop_front();
        if (med !== em || cnt !== ec || drp !== ed)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat %0d: exp median_x2=%0d count=%0d dropped=%0b, got %0d %0d %0b",
                         beats, em, ec, ed, med, cnt, drp);
        end
    endfunction

    function int pending();
        return exp_median.size();
    endfunction
endclass

module tb_top;
    localparam int RANDOM_ITEMS = 1830;
    localparam int CALM_FROM    = 1650;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [17:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [18:0] median_x2;
    logic [10:0]        element_count;
    logic               dropped;

    median_scoreboard sb;
    bit calm;
    bit stall_done;
    int sent;

    running_median_two_heaps_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_x2     (median_x2),
        .element_count (element_count),
        .dropped       (dropped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(median_x2, element_count, dropped);
    end

    initial
    begin
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!stall_done && sb.beats >= 300)
            begin
                stall_done = 1'b1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    hold = $urandom_range(1, 13);
            end
        end
    end

    task automatic send(input logic signed [17:0] v);
        value    <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(v);
        sent++;
        if (sent >= CALM_FROM)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    function automatic logic signed [17:0] pick();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return 18'($urandom);
        else if (mode < 8)
            return 18'($signed($urandom_range(0, 40)) - 20);
        else if (mode == 8)
            return $urandom_range(0, 1) ? 18'sh1FFFF : -18'sh20000;
        else
            return 18'($urandom_range(0, 3) * 1000);
    endfunction

    initial
    begin
        logic signed [17:0] directed [20];
        int guard;
        sb = new();
        calm = 1'b0;
        stall_done = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        directed = '{18'sd0, 18'sh1FFFF, -18'sh20000, 18'sd0, 18'sd0, 18'sd1, -18'sd1,
                     18'sh1FFFF, 18'sh1FFFF, -18'sh20000, -18'sh20000, 18'sd5, 18'sd5,
                     18'sd6, 18'sd4, -18'sd3, 18'sd100, -18'sd100, 18'sd2, 18'sd3};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
            send(directed[k]);
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 600)
            begin
                in_valid <= 1'b0;
                guard = 0;
                while (sb.pending() != 0 && guard < 5000)
                begin
                    @(posedge clk);
                    guard++;
                end
            end
            send(pick());
        end
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        $display("samples sent %0d, result beats %0d, dropped at full storage %0d",
                 sent, sb.beats, sb.drops);
        $display("left unmatched %0d, unexpected beats %0d, mismatches %0d",
                 sb.pending(), sb.orphans, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("timeout after %0d samples", sent);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
sv/rmth_pkg.sv
sv/rmth_heap.sv
sv/running_median_two_heaps_unit.sv
verif/tb_top.sv
